// ===== hdl/qbs_pkg.sv =====
// Package for the queue of bounded stacks: request/response payload types,
// operation and status codes, and the control state type.
// No dependencies.
package qbs_pkg;

   localparam int unsigned KIND_W   = 1;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CAP_W    = 5;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   value_out;
      logic                is_empty;
   } rsp_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

// ===== hdl/qbs_entry_ram.sv =====
// Entry store: single write port, single registered read port.
// Depends on nothing beyond its parameters.
module qbs_entry_ram #(
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = 7,
   parameter int unsigned DATA_W = 32
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/queue_of_bounded_stacks.sv =====
// Queue of bounded stacks: LIFO within a stack block, FIFO across blocks.
// IDLE accepts and starts the RAM reads; EXEC applies the update and loads the response.
// Requests are taken only in IDLE, while the response register is empty or draining.
// Reset (synchronous): no blocks open, all fills zero, capacity 16; the entry RAM
// and the closed-block fill RAM are not cleared, entries are only used after a push.
// Depends on qbs_pkg and qbs_entry_ram.
module queue_of_bounded_stacks #(
   parameter int unsigned NUM_STACKS  = 8,
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  qbs_pkg::req_type req_payload,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qbs_pkg::rsp_type rsp_payload,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   import qbs_pkg::*;

   localparam int unsigned ENTRIES = NUM_STACKS * STACK_DEPTH;
   localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned BW      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int unsigned FW      = $clog2(STACK_DEPTH + 1);
   localparam int unsigned CW      = $clog2(NUM_STACKS + 1);
   localparam int unsigned CMPW    = (FW > CAP_W) ? FW : CAP_W;

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [BW-1:0]     head_ff, head_in;
   logic [BW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [FW-1:0]     head_fill_ff, head_fill_in;   // fill of head block
   logic [FW-1:0]     tail_fill_ff, tail_fill_in;   // fill of tail block
   logic [CAP_W-1:0]  cap_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   // captured request (payload, no reset)
   logic [KIND_W-1:0] kind_ff;
   logic [WORD_W-1:0] value_ff;

   logic              accept;
   logic              exec_en;

   // ---------------------------------------------------------------
   // Register port: single capacity register at byte address 0
   // ---------------------------------------------------------------
   logic cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cfg_wr) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = 32'(cap_ff);
      end
   end

   // Effective capacity: zero acts as one, clamp to STACK_DEPTH.
   logic [FW-1:0] eff_cap;

   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = FW'(1);
      end else if (CMPW'(cap_ff) > CMPW'(STACK_DEPTH)) begin
         eff_cap = FW'(STACK_DEPTH);
      end else begin
         eff_cap = FW'(cap_ff);
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: IDLE takes a request and launches the RAM reads,
   // EXEC applies the update and loads the response register.
   // ---------------------------------------------------------------
   assign accept = req_valid && req_ready;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            exec_en   = 1'b0;
         end
         S_EXEC: begin
            req_ready = 1'b0;
            exec_en   = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            exec_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_payload.kind;
         value_ff <= req_payload.value_in;
      end
   end

   // ---------------------------------------------------------------
   // Ring helpers
   // ---------------------------------------------------------------
   function automatic logic [BW-1:0] ring_next(input logic [BW-1:0] b);
      logic [BW-1:0] r;
      if (b == BW'(NUM_STACKS - 1)) begin
         r = '0;
      end else begin
         r = b + BW'(1);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] entry_addr(input logic [BW-1:0] b,
                                                input logic [FW-1:0] f);
      return AW'(b) * AW'(STACK_DEPTH) + AW'(f);
   endfunction

   logic [BW-1:0] head_nxt;
   logic [BW-1:0] tail_nxt;

   assign head_nxt = ring_next(head_ff);
   assign tail_nxt = ring_next(tail_ff);

   // ---------------------------------------------------------------
   // Closed-block fill RAM. Written when the tail moves on, read ahead
   // for the block behind the head so a retiring head finds its successor.
   // ---------------------------------------------------------------
   logic [FW-1:0] fill_mem [NUM_STACKS];
   logic [FW-1:0] fill_rd_ff;
   logic          fill_we;

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[tail_ff] <= tail_fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fill_rd_ff <= fill_mem[head_nxt];
      end
   end

   // ---------------------------------------------------------------
   // Entry RAM. Top of the head stack is fetched on accept; the push
   // write lands in EXEC, so reads and writes never share a cycle.
   // ---------------------------------------------------------------
   logic                  ent_we;
   logic [AW-1:0]         ent_waddr;
   logic [AW-1:0]         ent_raddr;
   logic [DATA_WIDTH-1:0] ent_wdata;
   logic [DATA_WIDTH-1:0] ent_rdata;

   assign ent_raddr = entry_addr(head_ff, head_fill_ff - FW'(1));
   assign ent_wdata = DATA_WIDTH'(value_ff);

   qbs_entry_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (AW),
      .DATA_W (DATA_WIDTH)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata)
   );

   // ---------------------------------------------------------------
   // Update. head_fill mirrors tail_fill whenever a single block is open.
   // ---------------------------------------------------------------
   logic          need_new;
   logic          ring_full;
   logic [FW-1:0] pop_fill;
   logic [CW-1:0] count_dec;
   logic [BW-1:0] new_tail;

   assign need_new  = (count_ff == '0) || (tail_fill_ff >= eff_cap);
   assign ring_full = (count_ff == CW'(NUM_STACKS));
   assign pop_fill  = head_fill_ff - FW'(1);
   assign count_dec = count_ff - CW'(1);
   assign new_tail  = (count_ff == '0) ? head_ff : tail_nxt;

   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      count_in         = count_ff;
      head_fill_in     = head_fill_ff;
      tail_fill_in     = tail_fill_ff;
      fill_we          = 1'b0;
      ent_we           = 1'b0;
      ent_waddr        = entry_addr(tail_ff, tail_fill_ff);
      rsp_in.status    = STATUS_OK;
      rsp_in.value_out = '0;

      if (exec_en) begin
         unique case (kind_ff)
            KIND_INSERT: begin
               priority if (need_new && ring_full) begin
                  rsp_in.status = STATUS_NO_FREE;
               end else if (need_new) begin
                  // close the old tail (if any) and open a fresh block
                  fill_we      = (count_ff != '0);
                  tail_in      = new_tail;
                  tail_fill_in = FW'(1);
                  count_in     = count_ff + CW'(1);
                  ent_we       = 1'b1;
                  ent_waddr    = entry_addr(new_tail, '0);
                  if (count_ff == '0) begin
                     head_fill_in = FW'(1);
                  end
               end else begin
                  ent_we       = 1'b1;
                  tail_fill_in = tail_fill_ff + FW'(1);
                  if (count_ff == CW'(1)) begin
                     head_fill_in = tail_fill_ff + FW'(1);
                  end
               end
            end
            KIND_REMOVE: begin
               if (count_ff == '0) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  rsp_in.value_out = WORD_W'(ent_rdata);
                  if (count_ff == CW'(1)) begin
                     tail_fill_in = pop_fill;
                  end
                  if (pop_fill == '0) begin
                     // head block drained: retire it
                     head_in  = head_nxt;
                     count_in = count_dec;
                     if (count_dec == CW'(1)) begin
                        head_fill_in = tail_fill_ff;
                     end else begin
                        head_fill_in = fill_rd_ff;
                     end
                  end else begin
                     head_fill_in = pop_fill;
                  end
               end
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end

      rsp_in.is_empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         head_fill_ff <= '0;
         tail_fill_ff <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         head_fill_ff <= head_fill_in;
         tail_fill_ff <= tail_fill_in;
      end
   end

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NUM_STACKS))
      else $error("open block count beyond ring size");

   a_single_block_fill: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(1)) |-> (head_fill_ff == tail_fill_ff))
      else $error("head and tail fill disagree with one block open");

   a_tail_fill_bound: assert property (@(posedge clock) disable iff (reset)
      tail_fill_ff <= FW'(STACK_DEPTH))
      else $error("tail fill beyond stack depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request not executed next cycle");

   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_en |=> rsp_valid_ff)
      else $error("executed request produced no response");

endmodule
